>>> rtl/vxr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxr_pkg - shared types and constants of the VXLAN encap/decap realigner
// Beat and result words, register codes, header constants.
// ----------------------------------------------------------------------------
package vxr_pkg;

	localparam int LANES      = 8;
	localparam int LANE_W     = 64;
	localparam int KEEP_W     = 64;
	localparam int NET_ID_W   = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IP_W       = 32;
	localparam int PORT_W     = 16;
	// lanes held over by decap (all but the first-on-wire lane)
	localparam int HELD_LANES = LANES - 1;
	localparam int HELD_KEEP_W = KEEP_W - 8;

	localparam logic [31:0] VX_FLAGS = 32'h0800_0000;
	localparam logic [7:0]  HDR_KEEP = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NET_ID   = 2'd0,
		REG_PEER_IP  = 2'd1,
		REG_OWN_PORT = 2'd2,
		REG_FAR_PORT = 2'd3
	} cfg_reg_t;

	// lane[7] is first on the wire
	typedef struct packed {
		logic                         func;
		logic [LANES-1:0][LANE_W-1:0] lane;
		logic [KEEP_W-1:0]            keep;
		logic                         last;
	} beat_t;

	typedef struct packed {
		logic                         to_user;
		logic [LANES-1:0][LANE_W-1:0] lane;
		logic [KEEP_W-1:0]            keep;
		logic                         last;
		logic                         run_end;
	} result_t;

	// results of one word offered to the result queue
	typedef struct packed {
		logic       valid;
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [IP_W-1:0]   peer_ip;
		logic [PORT_W-1:0] own_port;
		logic [PORT_W-1:0] far_port;
	} sideband_t;

endpackage
`default_nettype wire

>>> rtl/vxr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxr_ifs - channel interfaces of the VXLAN encap/decap realigner
// Beat input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface vxr_beat_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] in_lane_7;
	logic [63:0] in_lane_6;
	logic [63:0] in_lane_5;
	logic [63:0] in_lane_4;
	logic [63:0] in_lane_3;
	logic [63:0] in_lane_2;
	logic [63:0] in_lane_1;
	logic [63:0] in_lane_0;
	logic [63:0] in_keep;
	logic        in_last;

	modport source (output valid, func, in_lane_7, in_lane_6, in_lane_5, in_lane_4,
		in_lane_3, in_lane_2, in_lane_1, in_lane_0, in_keep, in_last, input ready);
	modport sink (input valid, func, in_lane_7, in_lane_6, in_lane_5, in_lane_4,
		in_lane_3, in_lane_2, in_lane_1, in_lane_0, in_keep, in_last, output ready);
endinterface

interface vxr_result_if;
	logic        valid;
	logic        ready;
	logic        to_user;
	logic [63:0] out_lane_7;
	logic [63:0] out_lane_6;
	logic [63:0] out_lane_5;
	logic [63:0] out_lane_4;
	logic [63:0] out_lane_3;
	logic [63:0] out_lane_2;
	logic [63:0] out_lane_1;
	logic [63:0] out_lane_0;
	logic [63:0] out_keep;
	logic        out_last;
	logic        run_end;

	modport source (output valid, to_user, out_lane_7, out_lane_6, out_lane_5, out_lane_4,
		out_lane_3, out_lane_2, out_lane_1, out_lane_0, out_keep, out_last, run_end,
		input ready);
	modport sink (input valid, to_user, out_lane_7, out_lane_6, out_lane_5, out_lane_4,
		out_lane_3, out_lane_2, out_lane_1, out_lane_0, out_keep, out_last, run_end,
		output ready);
	modport monitor (input valid, ready, to_user, out_lane_7, out_lane_6, out_lane_5,
		out_lane_4, out_lane_3, out_lane_2, out_lane_1, out_lane_0, out_keep, out_last,
		run_end);
endinterface

interface vxr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/vxr_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxr_cfg_regs - configuration register file
// Holds the VNI and the network-side sideband values.
// ----------------------------------------------------------------------------
module vxr_cfg_regs import vxr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	vxr_cfg_if.sink                   cfg,
	output logic      [NET_ID_W-1:0]  net_id,
	output sideband_t                 sideband
);

	logic [NET_ID_W-1:0] net_id_q;
	sideband_t           sb_q;

	assign cfg.ready = 1'b1;
	assign net_id    = net_id_q;
	assign sideband  = sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_id_q <= '0;
			sb_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_NET_ID:   net_id_q    <= cfg.data[NET_ID_W-1:0];
				REG_PEER_IP:  sb_q.peer_ip  <= cfg.data[IP_W-1:0];
				REG_OWN_PORT: sb_q.own_port <= cfg.data[PORT_W-1:0];
				REG_FAR_PORT: sb_q.far_port <= cfg.data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/vxr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxr_core - input stage and per-word encap/decap logic
// Registers the word, forms up to two results and advances the word's direction.
// ----------------------------------------------------------------------------
module vxr_core import vxr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire beat_t               beat,
	input  wire logic [NET_ID_W-1:0] net_id,
	input  wire logic                take,
	output logic                     busy,
	output push_t                    push
);

	typedef enum logic [1:0] {
		D_START  = 2'd0,
		D_MIDDLE = 2'd1,
		D_DROP   = 2'd3
	} dphase_t;

	logic                              valid_s1;
	beat_t                             beat_s1;
	dphase_t                           d_phase_q, d_phase_d;
	logic [HELD_LANES-1:0][LANE_W-1:0] d_held_q, d_held_d;
	logic [HELD_KEEP_W-1:0]            d_keep_q, d_keep_d;
	logic                              e_mid_q, e_mid_d;
	logic [LANE_W-1:0]                 e_lane_q, e_lane_d;
	logic [7:0]                        e_keep_q, e_keep_d;
	logic                              vni_ok;
	logic [LANE_W-1:0]                 e_first;
	logic [7:0]                        e_kfirst;

	assign busy = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1 <= beat;
		end
	end

	assign vni_ok   = (beat_s1.lane[7][31:8] == net_id);
	assign e_first  = e_mid_q ? e_lane_q : {VX_FLAGS, net_id, 8'h00};
	assign e_kfirst = e_mid_q ? e_keep_q : HDR_KEEP;

	always_comb begin
		push       = '0;
		push.valid = valid_s1;
		d_phase_d  = d_phase_q;
		d_held_d   = d_held_q;
		d_keep_d   = d_keep_q;
		e_mid_d    = e_mid_q;
		e_lane_d   = e_lane_q;
		e_keep_d   = e_keep_q;
		push.r0.to_user = !beat_s1.func;
		push.r1.to_user = !beat_s1.func;
		push.r0.run_end = 1'b1;
		push.r1.run_end = 1'b1;
		push.r1.last    = 1'b1;
		if (!beat_s1.func) begin
			// second result of a long tail: this word moved up 8 bytes
			push.r1.lane = {beat_s1.lane[HELD_LANES-1:0], {LANE_W{1'b0}}};
			push.r1.keep = {beat_s1.keep[HELD_KEEP_W-1:0], 8'h00};
			unique case (d_phase_q)
				D_MIDDLE: begin
					push.r0.lane = {d_held_q, beat_s1.lane[7]};
					push.r0.keep = {d_keep_q, beat_s1.keep[KEEP_W-1:HELD_KEEP_W]};
					if (!beat_s1.last) begin
						push.n   = 2'd1;
						d_held_d = beat_s1.lane[HELD_LANES-1:0];
						d_keep_d = beat_s1.keep[HELD_KEEP_W-1:0];
					end else if (!beat_s1.keep[HELD_KEEP_W-1]) begin
						push.n       = 2'd1;
						push.r0.last = 1'b1;
						d_phase_d    = D_START;
					end else begin
						push.n          = 2'd2;
						push.r0.run_end = 1'b0;
						d_phase_d       = D_START;
					end
				end
				D_DROP: begin
					if (beat_s1.last) begin
						d_phase_d = D_START;
					end
				end
				default: begin
					// start of packet: strip header, match VNI
					d_held_d = beat_s1.lane[HELD_LANES-1:0];
					d_keep_d = beat_s1.keep[HELD_KEEP_W-1:0];
					push.r0.lane = push.r1.lane;
					push.r0.keep = push.r1.keep;
					push.r0.last = 1'b1;
					if (vni_ok && beat_s1.last) begin
						push.n    = 2'd1;
						d_phase_d = D_START;
					end else if (vni_ok) begin
						d_phase_d = D_MIDDLE;
					end else begin
						d_phase_d = beat_s1.last ? D_START : D_DROP;
					end
				end
			endcase
		end else begin
			push.r0.lane = {e_first, beat_s1.lane[LANES-1:1]};
			push.r0.keep = {e_kfirst, beat_s1.keep[KEEP_W-1:8]};
			push.r1.lane = {beat_s1.lane[0], {(HELD_LANES*LANE_W){1'b0}}};
			push.r1.keep = {beat_s1.keep[7:0], {HELD_KEEP_W{1'b0}}};
			e_lane_d = beat_s1.lane[0];
			e_keep_d = beat_s1.keep[7:0];
			e_mid_d  = !beat_s1.last;
			if (!beat_s1.last) begin
				push.n = 2'd1;
			end else if (!beat_s1.keep[7]) begin
				push.n       = 2'd1;
				push.r0.last = 1'b1;
			end else begin
				push.n          = 2'd2;
				push.r0.run_end = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_phase_q <= D_START;
			e_mid_q   <= 1'b0;
		end else if (take) begin
			if (!beat_s1.func) begin
				d_phase_q <= d_phase_d;
			end else begin
				e_mid_q <= e_mid_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			d_held_q <= d_held_d;
			d_keep_q <= d_keep_d;
			e_lane_q <= e_lane_d;
			e_keep_q <= e_keep_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/vxr_res_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxr_res_queue - two-slot result queue
// Takes zero to two results per word, presents them one per handshake.
// ----------------------------------------------------------------------------
module vxr_res_queue import vxr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       take,
	vxr_result_if.source result
);

	result_t    slot_q [2];
	result_t    slot_d [2];
	result_t    base;
	logic [1:0] cnt_q, cnt_d, kept;
	logic [2:0] need;
	logic       pop;

	assign pop  = (cnt_q != 2'd0) && result.ready;
	assign kept = cnt_q - {1'b0, pop};
	assign need = {1'b0, kept} + {1'b0, push.n};
	assign take = push.valid && (need <= 3'd2);
	assign base = pop ? slot_q[1] : slot_q[0];

	always_comb begin
		slot_d[0] = slot_q[0];
		slot_d[1] = slot_q[1];
		if (kept == 2'd1) begin
			slot_d[0] = base;
		end
		if (take) begin
			if (kept == 2'd0) begin
				slot_d[0] = push.r0;
				slot_d[1] = push.r1;
			end else if (kept == 2'd1) begin
				slot_d[1] = push.r0;
			end
		end
		cnt_d = take ? need[1:0] : kept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_d[0];
		slot_q[1] <= slot_d[1];
	end

	assign result.valid      = (cnt_q != 2'd0);
	assign result.to_user    = slot_q[0].to_user;
	assign result.out_lane_7 = slot_q[0].lane[7];
	assign result.out_lane_6 = slot_q[0].lane[6];
	assign result.out_lane_5 = slot_q[0].lane[5];
	assign result.out_lane_4 = slot_q[0].lane[4];
	assign result.out_lane_3 = slot_q[0].lane[3];
	assign result.out_lane_2 = slot_q[0].lane[2];
	assign result.out_lane_1 = slot_q[0].lane[1];
	assign result.out_lane_0 = slot_q[0].lane[0];
	assign result.out_keep   = slot_q[0].keep;
	assign result.out_last   = slot_q[0].last;
	assign result.run_end    = slot_q[0].run_end;

endmodule
`default_nettype wire

>>> rtl/vxlan_encap_decap_realign.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxlan_encap_decap_realign - VXLAN encapsulation / decapsulation realigner
// Strips or prepends the 8-byte VXLAN header on 512-bit beats.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  beat     in   func, in_lane_7..0, in_keep, in_last
//  result   out  to_user, out_lane_7..0, out_keep, out_last, run_end
//  cfg      in   index (0 net_id, 1 peer_ip, 2 own_port, 3 far_port), data
//
//  A word is registered, worked on combinationally and lands in a two-slot result
//  queue, which registers its results before they show on the result channel.
//  Sustained: one word per cycle while results are taken; a word that yields two
//  results holds the single output port for both of them.
//  Reset clears the phases, the queue count and the registers (all zero).
//  A stalled result stays put; the queue takes words while it has room, then
//  the input stage holds its word and drops ready.
// ----------------------------------------------------------------------------
module vxlan_encap_decap_realign import vxr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	vxr_beat_if.sink         beat,
	vxr_result_if.source     result,
	vxr_cfg_if.sink          cfg,
	output logic [IP_W-1:0]  sb_user,
	output logic [PORT_W-1:0] sb_id,
	output logic [PORT_W-1:0] sb_dest
);

	logic [NET_ID_W-1:0] net_id;
	sideband_t           sideband;
	beat_t               beat_w;
	push_t               push;
	logic                busy;
	logic                take;
	logic                load;

	// network-side sideband is static configuration
	assign sb_user = sideband.peer_ip;
	assign sb_id   = sideband.own_port;
	assign sb_dest = sideband.far_port;

	// gather the input word; lane 7 is first on the wire
	assign beat_w.func = beat.func;
	assign beat_w.lane = {beat.in_lane_7, beat.in_lane_6, beat.in_lane_5, beat.in_lane_4,
		beat.in_lane_3, beat.in_lane_2, beat.in_lane_1, beat.in_lane_0};
	assign beat_w.keep = beat.in_keep;
	assign beat_w.last = beat.in_last;

	// accept when the input stage is empty or drains this cycle
	assign beat.ready = !busy || take;
	assign load       = beat.valid && beat.ready;

	vxr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.net_id   (net_id),
		.sideband (sideband)
	);

	vxr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.beat   (beat_w),
		.net_id (net_id),
		.take   (take),
		.busy   (busy),
		.push   (push)
	);

	vxr_res_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.take   (take),
		.result (result)
	);

endmodule
`default_nettype wire

>>> rtl/vxr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vxr_checker - port-level checks of the VXLAN encap/decap realigner
// Watches the result channel over time.
// ----------------------------------------------------------------------------
module vxr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [63:0] out_lane_7,
	input wire logic [63:0] out_keep,
	input wire logic        out_last,
	input wire logic        run_end
);

	// no result shows while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !valid)
		else $error("result valid during reset");

	// the second result of a word follows right behind the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && !run_end |=> valid && run_end)
		else $error("second result of a word missing");

	// a first-of-two result never closes a packet
	a_pair_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !run_end |-> !out_last)
		else $error("out_last on non-final result of a word");

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_keep)
			&& $stable(out_lane_7) && $stable(out_last))
		else $error("stalled result changed");

endmodule

bind vxlan_encap_decap_realign vxr_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (result.valid),
	.ready      (result.ready),
	.out_lane_7 (result.out_lane_7),
	.out_keep   (result.out_keep),
	.out_last   (result.out_last),
	.run_end    (result.run_end)
);
`default_nettype wire

>>> sim/vxr_realign_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vxr_realign_checker - scoreboard of the VXLAN encap/decap realigner
// Watches the beat, result and register channels, predicts every result
// word and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
package vxr_tb_pkg;

	// direction of a beat word
	typedef enum logic {
		FUNC_NET  = 1'b0,
		FUNC_USER = 1'b1
	} func_t;

endpackage

module vxr_realign_checker import vxr_pkg::*; import vxr_tb_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	vxr_beat_if               beat,
	vxr_result_if.monitor     result,
	vxr_cfg_if                cfg,
	input  wire logic [IP_W-1:0]   sb_user,
	input  wire logic [PORT_W-1:0] sb_id,
	input  wire logic [PORT_W-1:0] sb_dest,
	output int                mismatches,
	output int                owed_count
);

	typedef enum logic [1:0] {
		DEC_START  = 2'd0,
		DEC_MIDDLE = 2'd1,
		DEC_DROP   = 2'd3
	} dec_phase_t;

	typedef enum logic {
		ENC_START  = 1'b0,
		ENC_MIDDLE = 1'b1
	} enc_phase_t;

	dec_phase_t                         dec_phase;
	logic [HELD_LANES-1:0][LANE_W-1:0]  dec_lanes;
	logic [HELD_KEEP_W-1:0]             dec_keep;
	enc_phase_t                         enc_phase;
	logic [LANE_W-1:0]                  enc_lane;
	logic [7:0]                         enc_keep;

	logic [NET_ID_W-1:0] vni;
	logic [IP_W-1:0]     peer_ip;
	logic [PORT_W-1:0]   own_port;
	logic [PORT_W-1:0]   far_port;

	result_t owed[$];
	beat_t   seen_beat;
	result_t seen_result;

	initial begin
		mismatches = 0;
		owed_count = 0;
	end

	task automatic miss(input string what, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
	endtask

	// Advance the encap/decap state by one beat and queue the words it owes.
	task automatic predict_beat(input beat_t b);
		result_t                      r;
		logic [LANES-1:0][LANE_W-1:0] w;
		r = '0;
		if (b.func == FUNC_NET) begin
			r.to_user = 1'b1;
			case (dec_phase)
				DEC_MIDDLE: begin
					w[7:1] = dec_lanes;
					w[0] = b.lane[7];
					r.lane = w;
					r.keep = {dec_keep, b.keep[63:56]};
					if (!b.last) begin
						r.run_end = 1'b1;
						owed.push_back(r);
						dec_lanes = b.lane[6:0];
						dec_keep = b.keep[55:0];
					end else if (!b.keep[55]) begin
						r.last = 1'b1;
						r.run_end = 1'b1;
						owed.push_back(r);
						dec_phase = DEC_START;
					end else begin
						owed.push_back(r);
						r.lane = {b.lane[6:0], 64'd0};
						r.keep = b.keep << 8;
						r.last = 1'b1;
						r.run_end = 1'b1;
						owed.push_back(r);
						dec_phase = DEC_START;
					end
				end
				DEC_DROP: begin
					if (b.last)
						dec_phase = DEC_START;
				end
				default: begin
					dec_lanes = b.lane[6:0];
					dec_keep = b.keep[55:0];
					if (b.lane[7][31:8] == vni) begin
						if (b.last) begin
							r.lane = {b.lane[6:0], 64'd0};
							r.keep = b.keep << 8;
							r.last = 1'b1;
							r.run_end = 1'b1;
							owed.push_back(r);
							dec_phase = DEC_START;
						end else begin
							dec_phase = DEC_MIDDLE;
						end
					end else begin
						dec_phase = b.last ? DEC_START : DEC_DROP;
					end
				end
			endcase
		end else begin
			w[6:0] = b.lane[7:1];
			if (enc_phase == ENC_MIDDLE) begin
				w[7] = enc_lane;
				r.keep = {enc_keep, b.keep[63:8]};
			end else begin
				w[7] = {VX_FLAGS, vni, 8'h00};
				r.keep = {HDR_KEEP, b.keep[63:8]};
			end
			r.lane = w;
			enc_lane = b.lane[0];
			enc_keep = b.keep[7:0];
			if (!b.last) begin
				r.run_end = 1'b1;
				owed.push_back(r);
				enc_phase = ENC_MIDDLE;
			end else begin
				enc_phase = ENC_START;
				if (!b.keep[7]) begin
					r.last = 1'b1;
					r.run_end = 1'b1;
					owed.push_back(r);
				end else begin
					owed.push_back(r);
					r.lane = {enc_lane, 448'd0};
					r.keep = {enc_keep, 56'd0};
					r.last = 1'b1;
					r.run_end = 1'b1;
					owed.push_back(r);
				end
			end
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (owed.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t result word with none expected: keep %h last %b",
					$time, got.keep, got.last);
			return;
		end
		want = owed.pop_front();
		if (got.to_user !== want.to_user)
			miss("to_user", 64'(want.to_user), 64'(got.to_user));
		for (int j = LANES - 1; j >= 0; j--)
			if (got.lane[j] !== want.lane[j])
				miss($sformatf("out_lane_%0d", j), want.lane[j], got.lane[j]);
		if (got.keep !== want.keep)
			miss("out_keep", want.keep, got.keep);
		if (got.last !== want.last)
			miss("out_last", 64'(want.last), 64'(got.last));
		if (got.run_end !== want.run_end)
			miss("run_end", 64'(want.run_end), 64'(got.run_end));
		// network words travel with the register sideband
		if (!want.to_user) begin
			if (sb_user !== peer_ip)
				miss("sb_user", 64'(peer_ip), 64'(sb_user));
			if (sb_id !== own_port)
				miss("sb_id", 64'(own_port), 64'(sb_id));
			if (sb_dest !== far_port)
				miss("sb_dest", 64'(far_port), 64'(sb_dest));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_phase = DEC_START;
			enc_phase = ENC_START;
			vni = '0;
			peer_ip = '0;
			own_port = '0;
			far_port = '0;
			owed.delete();
			owed_count = 0;
		end else begin
			if (result.valid && result.ready) begin
				seen_result.to_user = result.to_user;
				seen_result.lane = {result.out_lane_7, result.out_lane_6, result.out_lane_5,
					result.out_lane_4, result.out_lane_3, result.out_lane_2,
					result.out_lane_1, result.out_lane_0};
				seen_result.keep = result.out_keep;
				seen_result.last = result.out_last;
				seen_result.run_end = result.run_end;
				check_result(seen_result);
			end
			if (beat.valid && beat.ready) begin
				seen_beat.func = beat.func;
				seen_beat.lane = {beat.in_lane_7, beat.in_lane_6, beat.in_lane_5,
					beat.in_lane_4, beat.in_lane_3, beat.in_lane_2, beat.in_lane_1,
					beat.in_lane_0};
				seen_beat.keep = beat.in_keep;
				seen_beat.last = beat.in_last;
				predict_beat(seen_beat);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_NET_ID:   vni = cfg.data[NET_ID_W-1:0];
					REG_PEER_IP:  peer_ip = cfg.data[IP_W-1:0];
					REG_OWN_PORT: own_port = cfg.data[PORT_W-1:0];
					REG_FAR_PORT: far_port = cfg.data[PORT_W-1:0];
					default: ;
				endcase
			end
			owed_count = owed.size();
		end
	end

endmodule

>>> sim/vxlan_encap_decap_realign_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vxlan_encap_decap_realign_test - top of the realigner testbench
// Resets the block, programs its registers, sends directed and random packet
// words in both directions with random idling on both sides, and reports the
// verdict kept by the checker.
// ----------------------------------------------------------------------------
module vxlan_encap_decap_realign_test;

	import vxr_pkg::*;
	import vxr_tb_pkg::*;

	localparam int PHASE_WORDS = 300;

	logic              clk;
	logic              arst_n;
	logic [IP_W-1:0]   sb_user;
	logic [PORT_W-1:0] sb_id;
	logic [PORT_W-1:0] sb_dest;
	int                mismatches;
	int                owed_count;

	bit                squeeze;   // receiver held off for the pressure window
	bit                deep_run;  // random traffic under way
	bit                tx_calm;   // sender offers back to back
	logic [NET_ID_W-1:0] cur_vni;

	vxr_beat_if   beat_ch();
	vxr_result_if res_ch();
	vxr_cfg_if    cfg_ch();

	vxlan_encap_decap_realign u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat    (beat_ch),
		.result  (res_ch),
		.cfg     (cfg_ch),
		.sb_user (sb_user),
		.sb_id   (sb_id),
		.sb_dest (sb_dest)
	);

	vxr_realign_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat_ch),
		.result     (res_ch),
		.cfg        (cfg_ch),
		.sb_user    (sb_user),
		.sb_id      (sb_id),
		.sb_dest    (sb_dest),
		.mismatches (mismatches),
		.owed_count (owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pkt_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(1, 3);
		if (r < 90)
			return $urandom_range(4, 8);
		return $urandom_range(9, 24);
	endfunction

	// Final word of a packet: a byte prefix, a full word, or any mask at all.
	function automatic logic [63:0] tail_keep();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return ~({64{1'b1}} >> $urandom_range(1, 64));
		if (r < 65)
			return '1;
		return rand64();
	endfunction

	function automatic logic [63:0] body_keep();
		return ($urandom_range(0, 9) < 8) ? {64{1'b1}} : rand64();
	endfunction

	function automatic beat_t rand_beat(input logic func, input logic [63:0] keep,
			input logic last);
		beat_t b;
		b.func = func;
		for (int j = 0; j < LANES; j++)
			b.lane[j] = rand64();
		b.keep = keep;
		b.last = last;
		return b;
	endfunction

	function automatic beat_t flat_beat(input logic func, input logic [63:0] fill,
			input logic [63:0] keep, input logic last);
		beat_t b;
		b.func = func;
		for (int j = 0; j < LANES; j++)
			b.lane[j] = fill;
		b.keep = keep;
		b.last = last;
		return b;
	endfunction

	// Offer one word after an optional gap, hold it until taken, then return
	// on the next falling edge with valid still up.
	task automatic send_word(input beat_t b);
		int gap;
		gap = tx_calm ? 0 : idle_len();
		if (gap > 0) begin
			beat_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		beat_ch.valid     = 1'b1;
		beat_ch.func      = b.func;
		beat_ch.in_lane_7 = b.lane[7];
		beat_ch.in_lane_6 = b.lane[6];
		beat_ch.in_lane_5 = b.lane[5];
		beat_ch.in_lane_4 = b.lane[4];
		beat_ch.in_lane_3 = b.lane[3];
		beat_ch.in_lane_2 = b.lane[2];
		beat_ch.in_lane_1 = b.lane[1];
		beat_ch.in_lane_0 = b.lane[0];
		beat_ch.in_keep   = b.keep;
		beat_ch.in_last   = b.last;
		@(posedge clk);
		while (!beat_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write one register once the block has gone quiet.
	task automatic set_reg(input cfg_reg_t idx, input logic [31:0] val);
		beat_ch.valid = 1'b0;
		while (owed_count != 0)
			@(negedge clk);
		// let words that owe nothing clear the pipeline
		repeat (4) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		if (idx == REG_NET_ID)
			cur_vni = val[NET_ID_W-1:0];
	endtask

	task automatic write_all(input logic [31:0] v_net, input logic [31:0] v_ip,
			input logic [31:0] v_own, input logic [31:0] v_far);
		set_reg(REG_NET_ID, v_net);
		set_reg(REG_PEER_IP, v_ip);
		set_reg(REG_OWN_PORT, v_own);
		set_reg(REG_FAR_PORT, v_far);
	endtask

	// Result side: runs of ready, broken by gaps, with long clean stretches.
	initial begin
		int run;
		int gap;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			repeat (run) begin
				@(negedge clk);
				res_ch.ready = !squeeze;
			end
			gap = idle_len();
			repeat (gap) begin
				@(negedge clk);
				res_ch.ready = 1'b0;
			end
		end
	end

	// Pressure: twice during random traffic, hold the result side off long
	// enough for the result queue to fill and the beat side to stall.
	initial begin
		squeeze = 1'b0;
		wait (deep_run);
		repeat (2) begin
			repeat ($urandom_range(20, 80)) @(posedge clk);
			squeeze <= 1'b1;
			repeat (400) @(posedge clk);
			squeeze <= 1'b0;
		end
	end

	initial begin
		int       sent;
		int       net_left;
		int       user_left;
		bit       net_bad;
		bit       fresh;
		func_t    dir;
		beat_t    b;
		logic [63:0] k;

		// drive every input to a known value from time zero
		beat_ch.valid     = 1'b0;
		beat_ch.func      = FUNC_NET;
		beat_ch.in_lane_7 = '0;
		beat_ch.in_lane_6 = '0;
		beat_ch.in_lane_5 = '0;
		beat_ch.in_lane_4 = '0;
		beat_ch.in_lane_3 = '0;
		beat_ch.in_lane_2 = '0;
		beat_ch.in_lane_1 = '0;
		beat_ch.in_lane_0 = '0;
		beat_ch.in_keep   = '0;
		beat_ch.in_last   = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_NET_ID;
		cfg_ch.data       = '0;
		tx_calm           = 1'b0;
		deep_run          = 1'b0;
		cur_vni           = '0;
		arst_n            = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, all registers at their top value: an all-ones word
		// carries the matching VNI, an all-zeros word does not.
		write_all('1, '1, '1, '1);
		// decap: single matching word
		send_word(flat_beat(FUNC_NET, '1, '1, 1'b1));
		// decap: single word with the wrong VNI, drop it
		send_word(flat_beat(FUNC_NET, '0, '1, 1'b1));
		// decap: short tail that fits into the joined word
		send_word(flat_beat(FUNC_NET, '1, '1, 1'b0));
		send_word(flat_beat(FUNC_NET, '0, 64'hFF00_0000_0000_0000, 1'b1));
		// decap: middle word, then a full tail that spills into a second word
		send_word(flat_beat(FUNC_NET, '1, '1, 1'b0));
		send_word(rand_beat(FUNC_NET, '1, 1'b0));
		send_word(flat_beat(FUNC_NET, '1, '1, 1'b1));
		// decap: wrong VNI over several words, all dropped
		send_word(flat_beat(FUNC_NET, '0, '1, 1'b0));
		send_word(flat_beat(FUNC_NET, '1, '1, 1'b0));
		send_word(flat_beat(FUNC_NET, '1, '1, 1'b1));
		// encap: single full word, tail spills into a second word
		send_word(flat_beat(FUNC_USER, '1, '1, 1'b1));
		// encap: single word whose last byte slot is empty, no spill
		send_word(flat_beat(FUNC_USER, '0, 64'hFFFF_FFFF_FFFF_FF00, 1'b1));
		// encap: two words, full tail
		send_word(rand_beat(FUNC_USER, '1, 1'b0));
		send_word(flat_beat(FUNC_USER, '0, '1, 1'b1));
		// both directions interleaved, one-byte decap tail, encap tail in the
		// last byte slot only
		send_word(flat_beat(FUNC_NET, '1, '1, 1'b0));
		send_word(flat_beat(FUNC_USER, '0, '1, 1'b0));
		send_word(rand_beat(FUNC_NET, 64'h8000_0000_0000_0000, 1'b1));
		send_word(flat_beat(FUNC_USER, '1, 64'h0000_0000_0000_00FF, 1'b1));

		// Random part: packets in both directions interleaved word by word,
		// one register setting per phase, open packets closed before a change.
		deep_run = 1'b1;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0:       write_all('0, '0, '0, '0);
				4:       write_all('1, '1, '1, '1);
				default: write_all($urandom, $urandom, $urandom, $urandom);
			endcase
			tx_calm = (phase == 2);
			sent = 0;
			net_left = 0;
			user_left = 0;
			while (sent < PHASE_WORDS || net_left != 0 || user_left != 0) begin
				if (sent < PHASE_WORDS || (net_left != 0 && user_left != 0))
					dir = func_t'($urandom_range(0, 1));
				else
					dir = (user_left != 0) ? FUNC_USER : FUNC_NET;
				if (dir == FUNC_NET) begin
					fresh = (net_left == 0);
					if (fresh) begin
						net_left = pkt_len();
						net_bad = ($urandom_range(0, 9) == 0);
					end
					k = (net_left == 1) ? tail_keep() : body_keep();
					b = rand_beat(FUNC_NET, k, net_left == 1);
					// stamp the VNI on the opening word, wrong now and then
					if (fresh)
						b.lane[7][31:8] = net_bad ?
							cur_vni ^ NET_ID_W'($urandom_range(1, 24'hFF_FFFF)) : cur_vni;
					net_left--;
					if (!net_bad)
						sent++;
				end else begin
					if (user_left == 0)
						user_left = pkt_len();
					k = (user_left == 1) ? tail_keep() : body_keep();
					b = rand_beat(FUNC_USER, k, user_left == 1);
					user_left--;
					sent++;
				end
				send_word(b);
			end
		end

		// drain, then give the pipeline more time to settle
		beat_ch.valid = 1'b0;
		while (owed_count != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && owed_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
